[rtl/sdrr_pkg.sv]
package sdrr_pkg;

   localparam int NUM_SETS    = 2048;
   localparam int SET_BITS    = $clog2(NUM_SETS);
   localparam int NUM_WAYS    = 16;
   localparam int WAY_BITS    = $clog2(NUM_WAYS);
   localparam int SIG_ENTRIES = 16384;
   localparam int SIG_BITS    = $clog2(SIG_ENTRIES);
   localparam int SIG_SHIFT   = 4;
   localparam int SEL_BITS    = 10;

   localparam int RRPV_W   = 2;
   localparam int CNT_BITS = 2;
   localparam logic [RRPV_W-1:0]   RRPV_TOP  = 2'd3;
   localparam logic [RRPV_W-1:0]   RRPV_MID  = 2'd2;
   localparam logic [RRPV_W-1:0]   RRPV_NEAR = 2'd0;
   localparam logic [CNT_BITS-1:0] CNT_TOP   = 2'd3;
   localparam logic [CNT_BITS-1:0] CNT_START = 2'd1;
   localparam logic [SEL_BITS-1:0] SEL_TOP   = SEL_BITS'((1 << SEL_BITS) - 1);
   localparam logic [SEL_BITS-1:0] SEL_START = SEL_BITS'(((1 << SEL_BITS) - 1) / 2);

   localparam int CLR_DEPTH = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
   localparam int CLR_BITS  = $clog2(CLR_DEPTH);

   localparam int OPCODE_W = 2;
   localparam int SET_W    = 11;
   localparam int WAY_W    = 4;
   localparam int PC_W     = 64;
   localparam int DRAW_W   = 5;
   localparam int REQ_SET_LSB   = 0;
   localparam int REQ_WAY_LSB   = REQ_SET_LSB + SET_W;
   localparam int REQ_PC_LSB    = REQ_WAY_LSB + WAY_W;
   localparam int REQ_DRAW_LSB  = REQ_PC_LSB + PC_W;
   localparam int REQ_PAYLOAD   = REQ_DRAW_LSB + DRAW_W;
   localparam int REQ_DATA_BITS = ((REQ_PAYLOAD + 7) / 8) * 8;

   localparam int VICTIM_W        = 4;
   localparam int RSP_VICTIM_LSB  = 0;
   localparam int RSP_RRPV_LSB    = RSP_VICTIM_LSB + VICTIM_W;
   localparam int RSP_SEL_LSB     = RSP_RRPV_LSB + RRPV_W;
   localparam int RSP_PAYLOAD     = RSP_SEL_LSB + SEL_BITS;
   localparam int RSP_DATA_BITS   = ((RSP_PAYLOAD + 7) / 8) * 8;

   localparam int LEADER_W = 11;
   localparam int THRESH_W = 2;
   localparam logic [LEADER_W-1:0] LEADER_RESET = 11'd64;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 2'd2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_SEL_BIT   = 2;
   localparam logic REG_LEADER = 1'b0;
   localparam logic REG_THRESH = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_VICTIM = 2'd0,
      OP_HIT    = 2'd1,
      OP_FILL   = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [RRPV_W-1:0]   rrpv;
      logic                reused;
      logic [SIG_BITS-1:0] sig;
   } line_type;

   typedef line_type [NUM_WAYS-1:0] row_type;

   localparam int ROW_BITS = $bits(row_type);

   typedef struct packed {
      logic [LEADER_W-1:0] leader_sets;
      logic [THRESH_W-1:0] reuse_threshold;
   } cfg_type;

endpackage

[rtl/ship_dip_rrip_replacement_top.sv]
// Cache replacement engine: 2-bit RRIP with per-signature reuse counters and
// SRRIP/BRRIP set dueling. Per-set line state (RRPV, reuse flag, signature)
// lives in one row-wide RAM read once per word and written at most once per
// word; the reuse counters live in a second RAM. A word is taken only when the
// engine is idle: a victim request (or unused opcode 3) needs the row read, a
// hit also a counter read-modify-write and a fill both of these and the
// dependent prediction read. The next word is taken the cycle after a
// result is registered, even if the result is not yet taken; a result still
// waiting stalls the following one. After reset a clearing pass sets every
// line to RRPV 3 and every counter to 1; no word is taken during it, while
// register writes are accepted. Registers: 0x0 leader sets per policy, 0x4
// reuse threshold.
module ship_dip_rrip_replacement_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // set_index[10:0], way_index[14:11], program_counter[78:15], bimodal_draw[83:79]
   input  logic [sdrr_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // opcode[1:0]
   input  logic [sdrr_pkg::OPCODE_W-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // victim_way[3:0], inserted_rrpv[5:4], policy_selector[15:6]
   output logic [sdrr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sdrr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sdrr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [sdrr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import sdrr_pkg::*;

   cfg_type cfg;

   sdrr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdrr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("engine took a word while busy");

   a_victim_only_on_request: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[RSP_VICTIM_LSB +: VICTIM_W] != '0)
      |-> rsp_tdata[RSP_RRPV_LSB +: RRPV_W] == RRPV_TOP)
      else $error("nonzero victim with an inserted RRPV other than distant");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("engine ready before the clearing pass");

endmodule

[rtl/sdrr_ram.sv]
module sdrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sdrr_csr.sv]
module sdrr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sdrr_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [sdrr_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [sdrr_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output sdrr_pkg::cfg_type                  cfg
);
   import sdrr_pkg::*;

   logic [LEADER_W-1:0] leader_ff, leader_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic                wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      leader_in = leader_ff;
      thresh_in = thresh_ff;
      if (wr_hit) begin
         if (csr_paddr[CSR_SEL_BIT] == REG_THRESH) begin
            thresh_in = csr_pwdata[THRESH_W-1:0];
         end else begin
            leader_in = csr_pwdata[LEADER_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_ff <= LEADER_RESET;
         thresh_ff <= THRESH_RESET;
      end else begin
         leader_ff <= leader_in;
         thresh_ff <= thresh_in;
      end
   end

   assign csr_prdata = (csr_paddr[CSR_SEL_BIT] == REG_THRESH)
                       ? CSR_DATA_BITS'(thresh_ff) : CSR_DATA_BITS'(leader_ff);

   assign cfg.leader_sets     = leader_ff;
   assign cfg.reuse_threshold = thresh_ff;

endmodule

[rtl/sdrr_core.sv]
module sdrr_core (
   input  logic                               clock,
   input  logic                               reset,
   input  sdrr_pkg::cfg_type                  cfg,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sdrr_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic [sdrr_pkg::OPCODE_W-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sdrr_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import sdrr_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_ROW, S_TRAIN, S_PRED} state_type;

   function automatic row_type clear_row();
      row_type r;
      for (int i = 0; i < NUM_WAYS; i++) begin
         r[i].rrpv   = RRPV_TOP;
         r[i].reused = 1'b0;
         r[i].sig    = '0;
      end
      return r;
   endfunction

   function automatic logic [CNT_BITS-1:0] cnt_up(input logic [CNT_BITS-1:0] c);
      return (c < CNT_TOP) ? c + 1'b1 : c;
   endfunction

   function automatic logic [CNT_BITS-1:0] cnt_down(input logic [CNT_BITS-1:0] c);
      return (c != '0) ? c - 1'b1 : c;
   endfunction

   state_type               state_ff, state_in;
   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [SET_BITS-1:0]     set_ff, set_in;
   logic [WAY_BITS-1:0]     way_ff, way_in;
   logic [SIG_BITS-1:0]     nsig_ff, nsig_in;
   logic [DRAW_W-1:0]       draw_ff, draw_in;
   logic [SEL_BITS-1:0]     sel_ff, sel_in;
   logic                    fwd_ff, fwd_in;
   logic [CNT_BITS-1:0]     trained_ff, trained_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VICTIM_W-1:0]     rsp_victim_ff, rsp_victim_in;
   logic [RRPV_W-1:0]       rsp_rrpv_ff, rsp_rrpv_in;
   logic [SEL_BITS-1:0]     rsp_sel_ff, rsp_sel_in;
   logic                    clr_active_ff, clr_active_in;
   logic [CLR_BITS-1:0]     clr_idx_ff, clr_idx_in;

   logic                    row_wr_en, row_rd_en;
   logic [SET_BITS-1:0]     row_wr_addr, row_rd_addr;
   row_type                 row_wr, row_rd;
   logic [ROW_BITS-1:0]     row_rd_raw;
   logic                    cnt_wr_en, cnt_rd_en;
   logic [SIG_BITS-1:0]     cnt_wr_addr, cnt_rd_addr;
   logic [CNT_BITS-1:0]     cnt_wr_data, cnt_rd_data;

   logic                    accept, out_free;
   line_type                line_cur;
   logic [LEADER_W:0]       set_w;
   logic                    srrip_lead, brrip_lead, follow_srrip;
   logic                    any3, any2, any1;
   logic [RRPV_W-1:0]       rmax, delta, fill_rrpv;
   logic [WAY_BITS-1:0]     victim;
   row_type                 aged;
   logic [CNT_BITS-1:0]     trained, pred;

   assign row_rd     = row_type'(row_rd_raw);
   assign req_tready = (state_ff == S_IDLE) & ~clr_active_ff;
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign line_cur   = row_rd[way_ff];

   assign set_w      = (LEADER_W + 1)'(set_ff);
   assign srrip_lead = set_w < {1'b0, cfg.leader_sets};
   assign brrip_lead = ~srrip_lead & (set_w < {cfg.leader_sets, 1'b0});

   always_comb begin
      any3 = 1'b0;
      any2 = 1'b0;
      any1 = 1'b0;
      for (int i = 0; i < NUM_WAYS; i++) begin
         any3 = any3 | (row_rd[i].rrpv == 2'd3);
         any2 = any2 | (row_rd[i].rrpv == 2'd2);
         any1 = any1 | (row_rd[i].rrpv == 2'd1);
      end
      rmax  = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
      delta = RRPV_TOP - rmax;
      victim = '0;
      for (int i = NUM_WAYS - 1; i >= 0; i--) begin
         if (row_rd[i].rrpv == rmax) begin
            victim = WAY_BITS'(i);
         end
      end
      aged = row_rd;
      for (int i = 0; i < NUM_WAYS; i++) begin
         aged[i].rrpv = row_rd[i].rrpv + delta;
      end
   end

   assign trained = ((op_ff == OP_HIT) || line_cur.reused) ? cnt_up(cnt_rd_data)
                                                           : cnt_down(cnt_rd_data);
   assign pred    = fwd_ff ? trained_ff : cnt_rd_data;

   always_comb begin
      follow_srrip = srrip_lead | (~brrip_lead & (sel_ff > SEL_START));
      if (pred >= cfg.reuse_threshold) begin
         fill_rrpv = RRPV_NEAR;
      end else if (pred == '0) begin
         fill_rrpv = RRPV_TOP;
      end else if (follow_srrip || (draw_ff == '0)) begin
         fill_rrpv = RRPV_MID;
      end else begin
         fill_rrpv = RRPV_TOP;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      set_in        = set_ff;
      way_in        = way_ff;
      nsig_in       = nsig_ff;
      draw_in       = draw_ff;
      sel_in        = sel_ff;
      fwd_in        = fwd_ff;
      trained_in    = trained_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_victim_in = rsp_victim_ff;
      rsp_rrpv_in   = rsp_rrpv_ff;
      rsp_sel_in    = rsp_sel_ff;
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      row_wr_en     = 1'b0;
      row_wr_addr   = set_ff;
      row_wr        = row_rd;
      row_rd_en     = 1'b0;
      row_rd_addr   = req_tdata[REQ_SET_LSB +: SET_BITS];
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = line_cur.sig;
      cnt_wr_data   = trained;
      cnt_rd_en     = 1'b0;
      cnt_rd_addr   = line_cur.sig;

      if (clr_active_ff) begin
         row_wr_en   = {1'b0, clr_idx_ff} < (CLR_BITS + 1)'(NUM_SETS);
         row_wr_addr = clr_idx_ff[SET_BITS-1:0];
         row_wr      = clear_row();
         cnt_wr_en   = {1'b0, clr_idx_ff} < (CLR_BITS + 1)'(SIG_ENTRIES);
         cnt_wr_addr = clr_idx_ff[SIG_BITS-1:0];
         cnt_wr_data = CNT_START;
         clr_idx_in  = clr_idx_ff + 1'b1;
         if (clr_idx_ff == CLR_BITS'(CLR_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_in     = req_tuser;
                  set_in    = req_tdata[REQ_SET_LSB +: SET_BITS];
                  way_in    = req_tdata[REQ_WAY_LSB +: WAY_BITS];
                  nsig_in   = req_tdata[REQ_PC_LSB + SIG_SHIFT +: SIG_BITS];
                  draw_in   = req_tdata[REQ_DRAW_LSB +: DRAW_W];
                  row_rd_en = 1'b1;
                  state_in  = S_ROW;
               end
            end
            S_ROW: begin
               case (op_ff)
                  OP_VICTIM: begin
                     if (out_free) begin
                        row_wr_en     = 1'b1;
                        row_wr        = aged;
                        rsp_valid_in  = 1'b1;
                        rsp_victim_in = VICTIM_W'(victim);
                        rsp_rrpv_in   = RRPV_TOP;
                        rsp_sel_in    = sel_ff;
                        state_in      = S_IDLE;
                     end
                  end
                  OP_HIT: begin
                     row_wr_en             = 1'b1;
                     row_wr[way_ff].rrpv   = RRPV_NEAR;
                     row_wr[way_ff].reused = 1'b1;
                     cnt_rd_en             = 1'b1;
                     state_in              = S_TRAIN;
                  end
                  OP_FILL: begin
                     cnt_rd_en = 1'b1;
                     state_in  = S_TRAIN;
                  end
                  default: begin
                     if (out_free) begin
                        rsp_valid_in  = 1'b1;
                        rsp_victim_in = '0;
                        rsp_rrpv_in   = RRPV_TOP;
                        rsp_sel_in    = sel_ff;
                        state_in      = S_IDLE;
                     end
                  end
               endcase
            end
            S_TRAIN: begin
               if (op_ff == OP_HIT) begin
                  if (out_free) begin
                     cnt_wr_en     = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_victim_in = '0;
                     rsp_rrpv_in   = RRPV_NEAR;
                     rsp_sel_in    = sel_ff;
                     state_in      = S_IDLE;
                  end
               end else begin
                  cnt_wr_en   = 1'b1;
                  cnt_rd_en   = 1'b1;
                  cnt_rd_addr = nsig_ff;
                  fwd_in      = nsig_ff == line_cur.sig;
                  trained_in  = trained;
                  if (srrip_lead) begin
                     if (sel_ff != '0) begin
                        sel_in = sel_ff - 1'b1;
                     end
                  end else if (brrip_lead) begin
                     if (sel_ff != SEL_TOP) begin
                        sel_in = sel_ff + 1'b1;
                     end
                  end
                  state_in = S_PRED;
               end
            end
            S_PRED: begin
               if (out_free) begin
                  row_wr_en             = 1'b1;
                  row_wr[way_ff].rrpv   = fill_rrpv;
                  row_wr[way_ff].reused = 1'b0;
                  row_wr[way_ff].sig    = nsig_ff;
                  rsp_valid_in          = 1'b1;
                  rsp_victim_in         = '0;
                  rsp_rrpv_in           = fill_rrpv;
                  rsp_sel_in            = sel_ff;
                  state_in              = S_IDLE;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sel_ff        <= SEL_START;
         rsp_valid_ff  <= 1'b0;
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         sel_ff        <= sel_in;
         rsp_valid_ff  <= rsp_valid_in;
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
      end
      op_ff         <= op_in;
      set_ff        <= set_in;
      way_ff        <= way_in;
      nsig_ff       <= nsig_in;
      draw_ff       <= draw_in;
      fwd_ff        <= fwd_in;
      trained_ff    <= trained_in;
      rsp_victim_ff <= rsp_victim_in;
      rsp_rrpv_ff   <= rsp_rrpv_in;
      rsp_sel_ff    <= rsp_sel_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_sel_ff, rsp_rrpv_ff, rsp_victim_ff});

   sdrr_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (ROW_BITS'(row_wr)),
      .rd_en   (row_rd_en),
      .rd_addr (row_rd_addr),
      .rd_data (row_rd_raw)
   );

   sdrr_ram #(
      .WIDTH (CNT_BITS),
      .DEPTH (SIG_ENTRIES)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

endmodule

[tb/ship_dip_rrip_replacement_top_tb.sv]
module ship_dip_rrip_replacement_top_tb;
   import sdrr_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int NUM_LINES   = NUM_SETS * NUM_WAYS;
   localparam int IDLE_LIMIT  = 50000;
   localparam int PHASE_WORDS = 222;
   localparam int SET_POOL    = 12;
   localparam int SIG_POOL    = 8;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic [SET_W-1:0]    set_idx;
      logic [WAY_W-1:0]    way;
      logic [PC_W-1:0]     pc;
      logic [DRAW_W-1:0]   draw;
   } access_type;

   typedef struct packed {
      logic [VICTIM_W-1:0] victim;
      logic [RRPV_W-1:0]   rrpv;
      logic [SEL_BITS-1:0] sel;
   } outcome_type;

   typedef struct {
      access_type  acc;
      bit          typed;
      outcome_type want;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic [OPCODE_W-1:0]       req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   logic [RRPV_W-1:0]    line_rrpv [NUM_LINES];
   logic [SIG_BITS-1:0]  line_sig [NUM_LINES];
   bit                   line_reused [NUM_LINES];
   logic [CNT_BITS-1:0]  sig_count [SIG_ENTRIES];
   logic [SEL_BITS-1:0]  duel_sel;
   logic [LEADER_W-1:0]  leader_sets;
   logic [THRESH_W-1:0]  reuse_thresh;

   logic [SET_W-1:0]    set_pool [SET_POOL];
   logic [SIG_BITS-1:0] sig_pool [SIG_POOL];

   outcome_type pending_outcomes [$];
   outcome_type oldest;
   int       errors = 0;
   int       burst_left = 0;
   int       stall_mode = 0;
   int       clk_count = 0;
   int       idle_count = 0;

   ship_dip_rrip_replacement_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic outcome_type rrip_update(input access_type a);
      int unsigned s, base, line, lead;
      logic [SIG_BITS-1:0] sig;
      logic [CNT_BITS-1:0] pred;
      bit found, srrip_lead, brrip_lead, follow_srrip;
      outcome_type r;
      s = a.set_idx % NUM_SETS;
      base = s * NUM_WAYS;
      line = base + a.way % NUM_WAYS;
      lead = leader_sets;
      srrip_lead = s < lead;
      brrip_lead = !srrip_lead && s < 2 * lead;
      r.victim = '0;
      r.rrpv = RRPV_TOP;
      found = 1'b0;
      case (a.op)
         OP_VICTIM: begin
            for (int rnd = 0; rnd < 4 && !found; rnd++) begin
               for (int i = 0; i < NUM_WAYS; i++)
                  if (!found && line_rrpv[base + i] == RRPV_TOP) begin
                     found = 1'b1;
                     r.victim = VICTIM_W'(i);
                  end
               if (!found)
                  for (int i = 0; i < NUM_WAYS; i++)
                     if (line_rrpv[base + i] != RRPV_TOP) line_rrpv[base + i]++;
            end
         end
         OP_HIT: begin
            line_rrpv[line] = RRPV_NEAR;
            line_reused[line] = 1'b1;
            if (sig_count[line_sig[line]] != CNT_TOP) sig_count[line_sig[line]]++;
            r.rrpv = RRPV_NEAR;
         end
         OP_FILL: begin
            if (line_reused[line]) begin
               if (sig_count[line_sig[line]] != CNT_TOP) sig_count[line_sig[line]]++;
            end else begin
               if (sig_count[line_sig[line]] != '0) sig_count[line_sig[line]]--;
            end
            if (srrip_lead) begin
               if (duel_sel != '0) duel_sel--;
            end else if (brrip_lead) begin
               if (duel_sel != SEL_TOP) duel_sel++;
            end
            sig = a.pc[SIG_SHIFT +: SIG_BITS];
            line_sig[line] = sig;
            line_reused[line] = 1'b0;
            pred = sig_count[sig];
            if (pred >= reuse_thresh) begin
               r.rrpv = RRPV_NEAR;
            end else if (pred == '0) begin
               r.rrpv = RRPV_TOP;
            end else begin
               follow_srrip = srrip_lead || (!brrip_lead && duel_sel > SEL_START);
               r.rrpv = (follow_srrip || a.draw == '0) ? RRPV_MID : RRPV_TOP;
            end
            line_rrpv[line] = r.rrpv;
         end
         default: begin
         end
      endcase
      r.sel = duel_sel;
      return r;
   endfunction

   function automatic directed_row_type dir_row(input logic [OPCODE_W-1:0] op,
                                                input logic [SET_W-1:0] set_idx,
                                                input logic [WAY_W-1:0] way,
                                                input logic [PC_W-1:0] pc,
                                                input logic [DRAW_W-1:0] draw,
                                                input bit typed,
                                                input logic [VICTIM_W-1:0] victim,
                                                input logic [RRPV_W-1:0] rrpv,
                                                input logic [SEL_BITS-1:0] sel);
      directed_row_type row;
      row.acc.op = op;
      row.acc.set_idx = set_idx;
      row.acc.way = way;
      row.acc.pc = pc;
      row.acc.draw = draw;
      row.typed = typed;
      row.want.victim = victim;
      row.want.rrpv = rrpv;
      row.want.sel = sel;
      return row;
   endfunction

   function automatic access_type random_access(input logic [OPCODE_W-1:0] op,
                                                input bit pooled);
      access_type a;
      a.op = op;
      a.set_idx = pooled ? set_pool[$urandom_range(0, SET_POOL - 1)] : SET_W'($urandom);
      a.way = WAY_W'($urandom);
      a.pc = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0)
         a.pc[SIG_SHIFT +: SIG_BITS] = sig_pool[$urandom_range(0, SIG_POOL - 1)];
      a.draw = ($urandom_range(0, 3) == 0) ? '0 : DRAW_W'($urandom);
      return a;
   endfunction

   task automatic send_access(input access_type a, input bit typed, input outcome_type want,
                              output outcome_type got);
      req_tvalid <= 1'b1;
      req_tuser <= a.op;
      req_tdata <= REQ_DATA_BITS'({a.draw, a.pc, a.way, a.set_idx});
      do @(posedge clock); while (!req_tready);
      got = rrip_update(a);
      pending_outcomes.push_back(typed ? want : got);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
      end
   endtask

   // drop valid and hold until every outstanding word has come back
   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_cycle(input bit wr, input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] wdata,
                            output logic [CSR_DATA_BITS-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_reg(input logic idx, input logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_ADDR_BITS-1:0] addr;
      logic [CSR_DATA_BITS-1:0] rd;
      addr = CSR_ADDR_BITS'(idx) << CSR_SEL_BIT;
      csr_cycle(1'b1, addr, value, rd);
      csr_cycle(1'b0, addr, '0, rd);
      if (rd !== value) begin
         $display("%0t: register 0x%0h expected 0x%0h got 0x%0h", $time, addr, value, rd);
         errors++;
      end
      if (idx == REG_LEADER) leader_sets = LEADER_W'(value);
      else reuse_thresh = THRESH_W'(value);
   endtask

   task automatic random_phase(input int words);
      int unsigned lead, hi;
      int sent, hits, k;
      bit paused;
      access_type a, b;
      outcome_type got, unused;
      lead = leader_sets;
      hi = (2 * lead > NUM_SETS) ? NUM_SETS : 2 * lead;
      for (int i = 0; i < SET_POOL; i++) begin
         k = $urandom_range(0, 2);
         if (k == 0 && lead > 0)
            set_pool[i] = SET_W'($urandom_range(0, lead - 1));
         else if (k == 1 && lead > 0 && lead < NUM_SETS)
            set_pool[i] = SET_W'($urandom_range(lead, hi - 1));
         else
            set_pool[i] = SET_W'($urandom_range(0, NUM_SETS - 1));
      end
      for (int i = 0; i < SIG_POOL; i++) sig_pool[i] = SIG_BITS'($urandom);
      sent = 0;
      paused = 1'b0;
      while (sent < words) begin
         if (!paused && sent >= words / 2) begin
            paused = 1'b1;
            drain();
         end
         if ($urandom_range(0, 9) < 6) begin
            // victim, fill of the chosen way, then up to two hits in the same set
            a = random_access(OP_VICTIM, 1'b1);
            send_access(a, 1'b0, '0, got);
            b = random_access(OP_FILL, 1'b1);
            b.set_idx = a.set_idx;
            b.way = got.victim;
            send_access(b, 1'b0, '0, unused);
            hits = $urandom_range(0, 2);
            for (int h = 0; h < hits; h++) begin
               b = random_access(OP_HIT, 1'b1);
               b.set_idx = a.set_idx;
               if ($urandom_range(0, 1)) b.way = got.victim;
               send_access(b, 1'b0, '0, unused);
            end
            sent += 2 + hits;
         end else begin
            k = $urandom_range(0, 19);
            a = random_access((k == 0) ? OP_UNUSED : OPCODE_W'(k % 3),
                              1'($urandom_range(0, 1)));
            send_access(a, 1'b0, '0, unused);
            sent++;
         end
      end
      drain();
   endtask

   always @(posedge clock) begin
      clk_count <= clk_count + 1;
      if (clk_count % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ((clk_count / 4) % 2 == 0);
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result 0x%0h", $time, rsp_tdata);
            errors++;
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_tdata[RSP_VICTIM_LSB +: VICTIM_W] !== oldest.victim) begin
               $display("%0t: victim_way expected %0d got %0d", $time, oldest.victim,
                        rsp_tdata[RSP_VICTIM_LSB +: VICTIM_W]);
               errors++;
            end
            if (rsp_tdata[RSP_RRPV_LSB +: RRPV_W] !== oldest.rrpv) begin
               $display("%0t: inserted_rrpv expected %0d got %0d", $time, oldest.rrpv,
                        rsp_tdata[RSP_RRPV_LSB +: RRPV_W]);
               errors++;
            end
            if (rsp_tdata[RSP_SEL_LSB +: SEL_BITS] !== oldest.sel) begin
               $display("%0t: policy_selector expected %0d got %0d", $time, oldest.sel,
                        rsp_tdata[RSP_SEL_LSB +: SEL_BITS]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_count <= 0;
      end else if (idle_count >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      directed_row_type rows [$];
      outcome_type got;
      logic [LEADER_W-1:0] leader_plan [5];
      logic [THRESH_W-1:0] thresh_plan [5];
      leader_plan = '{11'd0, 11'd1024, 11'd2047, 11'd3, 11'd200};
      thresh_plan = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd1};
      for (int i = 0; i < NUM_LINES; i++) begin
         line_rrpv[i] = RRPV_TOP;
         line_sig[i] = '0;
         line_reused[i] = 1'b0;
      end
      for (int i = 0; i < SIG_ENTRIES; i++) sig_count[i] = CNT_START;
      duel_sel = SEL_START;
      leader_sets = LEADER_RESET;
      reuse_thresh = THRESH_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      rows.push_back(dir_row(OP_VICTIM, 0, 0, '0, '0, 1, 0, RRPV_TOP, SEL_START));
      rows.push_back(dir_row(OP_VICTIM, 2047, 15, '1, '1, 1, 0, RRPV_TOP, SEL_START));
      rows.push_back(dir_row(OP_UNUSED, 100, 15, '1, '1, 1, 0, RRPV_TOP, SEL_START));
      rows.push_back(dir_row(OP_HIT, 0, 15, '0, '0, 1, 0, RRPV_NEAR, SEL_START));
      rows.push_back(dir_row(OP_VICTIM, 0, 5, '0, '0, 1, 0, RRPV_TOP, SEL_START));
      rows.push_back(dir_row(OP_FILL, 0, 15, '0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_FILL, 64, 0, '1, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_FILL, 65, 1, 64'h3FFF0, 5, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_FILL, 2000, 2, 64'h8000_0000_0001_2340, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_FILL, 2047, 14, 64'h2AAA0, 31, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_HIT, 2000, 2, '1, 31, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_FILL, 2001, 3, 64'h12340, 16, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_VICTIM, 2000, 9, '0, '0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_FILL, 1500, 7, '0, 0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_FILL, 1501, 8, 64'h5555_5555_5555_5555, 10, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_UNUSED, 0, 0, '0, '0, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_HIT, 1500, 7, 64'hAAAA_AAAA_AAAA_AAAA, 21, 0, 0, 0, 0));
      rows.push_back(dir_row(OP_VICTIM, 1500, 0, '0, '0, 0, 0, 0, 0));
      foreach (rows[i]) send_access(rows[i].acc, rows[i].typed, rows[i].want, got);
      drain();

      random_phase(PHASE_WORDS);
      for (int p = 0; p < 5; p++) begin
         write_reg(REG_LEADER, CSR_DATA_BITS'(leader_plan[p]));
         write_reg(REG_THRESH, CSR_DATA_BITS'(thresh_plan[p]));
         random_phase(PHASE_WORDS);
      end

      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
